@@ design/rrs_pkg.sv @@
// Shared types and action codes of the round-robin scheduler.
package rrs_pkg;

  localparam logic [2:0] ACT_SCHEDULE = 3'd0;
  localparam logic [2:0] ACT_CREATE   = 3'd1;
  localparam logic [2:0] ACT_REMOVE   = 3'd2;
  localparam logic [2:0] ACT_TASK_EN  = 3'd3;
  localparam logic [2:0] ACT_THR_EN   = 3'd4;
  localparam logic [2:0] ACT_RELEASE  = 3'd5;

  localparam int PERIOD_W = 32;
  localparam int TICK_W   = 32;
  localparam int SLICE_W  = 16;
  localparam int WORD_W   = PERIOD_W + TICK_W + SLICE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HOP,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   last_run;
    logic [SLICE_W-1:0]  slice;
  } task_word_t;

endpackage

@@ design/rrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rrs_pick.sv @@
// Circular first-set search over a request vector from a start index.
module rrs_pick #(
  parameter int N = 4
) (
  input  logic [N-1:0]                       req,
  input  logic [(N > 1 ? $clog2(N) : 1)-1:0] start,
  output logic [(N > 1 ? $clog2(N) : 1)-1:0] idx
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic          found;
  logic [IW:0]   sum;
  logic [IW-1:0] cand;

  always_comb begin
    found = 1'b0;
    idx   = start;
    sum   = '0;
    cand  = '0;
    for (int n = N - 1; n >= 0; n--) begin
      sum  = {1'b0, start} + (IW + 1)'(n);
      cand = (sum >= (IW + 1)'(N)) ? IW'(sum - (IW + 1)'(N)) : IW'(sum);
      if (req[cand]) begin
        found = 1'b1;
        idx   = cand;
      end
    end
    if (!found) begin
      idx = start;
    end
  end

endmodule

@@ design/thread_task_round_robin_scheduler_unit.sv @@
// Top level of the round-robin thread and task scheduler.
// Create, remove, enable, release: result valid the cycle after acceptance.
// Schedule: READ then RESP when the chosen thread holds a task, otherwise
// SCAN first (and HOP if none attaches), one task RAM read per cycle.
// One transaction at a time. Synchronous active-low reset clears the state,
// pointers, thread state and task flags; task RAM is written on create.
module thread_task_round_robin_scheduler_unit #(
  parameter int THREADS = 4,
  parameter int TASKS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_slot,
  input  logic        in_enable_flag,
  input  logic        in_loop_flag,
  input  logic [31:0] in_period_ticks,
  input  logic [15:0] in_quanta_budget,
  input  logic [31:0] in_now_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_thread_index,
  output logic        out_task_valid,
  output logic [3:0]  out_task_index,
  output logic [15:0] out_quanta,
  output logic        out_accepted,
  output logic        out_newly_attached
);

  localparam int HW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;

  rrs_pkg::state_t state_r, state_nxt;

  logic [HW-1:0] cur_r, cur_nxt;
  logic [TW-1:0] ptr_r, ptr_nxt;
  logic [THREADS-1:0] thr_en_r, thr_en_nxt, has_r, has_nxt;
  logic [TW-1:0] thr_task_r [THREADS];
  logic [TW-1:0] thr_task_nxt [THREADS];
  logic [TASKS-1:0] used_r, used_nxt, ten_r, ten_nxt, per_r, per_nxt, tkn_r, tkn_nxt;

  logic [TW:0]   cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt, pq_r, pq_nxt, pp_r, pp_nxt;
  logic [TW-1:0] pk_r, pk_nxt;
  logic          att_r, att_nxt;
  logic [31:0]   now_r, now_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  o_thr_r, o_thr_nxt;
  logic        o_tv_r, o_tv_nxt;
  logic [3:0]  o_tk_r, o_tk_nxt;
  logic [15:0] o_q_r, o_q_nxt;
  logic        o_acc_r, o_acc_nxt;
  logic        o_na_r, o_na_nxt;

  logic                   ram_we, ram_re;
  logic [TW-1:0]          ram_waddr, ram_raddr;
  rrs_pkg::task_word_t    ram_wdata, ram_rdata;

  logic [HW-1:0] start_en, pick_en, start_has, pick_has;
  logic          out_free, accept;
  logic [TW-1:0] slot_k, free_k, scan_k;
  logic [HW-1:0] slot_t;
  logic          free_found;
  logic [TW:0]   scan_sum;
  logic [TW:0]   pk_inc;
  logic [TW:0]   ptr_inc;
  logic          qual;

  rrs_ram #(.WIDTH(rrs_pkg::WORD_W), .DEPTH(TASKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrs_pick #(.N(THREADS)) u_pick_en (
    .req   (thr_en_r),
    .start (start_en),
    .idx   (pick_en)
  );

  rrs_pick #(.N(THREADS)) u_pick_has (
    .req   (has_r),
    .start (start_has),
    .idx   (pick_has)
  );

  assign out_free = !ov_r || !out_stall;
  assign in_stall = !((state_r == rrs_pkg::S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  assign start_en  = (32'(cur_r) + 1 >= THREADS) ? '0 : HW'(32'(cur_r) + 1);
  assign start_has = start_en;

  assign slot_k   = TW'(32'(in_slot));
  assign slot_t   = HW'(32'(in_slot));
  assign scan_sum = {1'b0, ptr_r} + cnt_r;
  assign scan_k   = (scan_sum >= (TW + 1)'(TASKS)) ? TW'(scan_sum - (TW + 1)'(TASKS))
                                                   : TW'(scan_sum);
  assign pk_inc   = {1'b0, pk_r} + 1'b1;
  assign ptr_inc  = {1'b0, ptr_r} + 1'b1;
  assign qual     = pq_r && (!pp_r ||
                    ((now_r - ram_rdata.last_run) >= ram_rdata.period));

  always_comb begin
    free_found = 1'b0;
    free_k     = '0;
    for (int k = TASKS - 1; k >= 0; k--) begin
      if (!used_r[k]) begin
        free_found = 1'b1;
        free_k     = TW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rrs_pkg::S_IDLE;
      cur_r    <= '0;
      ptr_r    <= '0;
      thr_en_r <= '0;
      has_r    <= '0;
      used_r   <= '0;
      ten_r    <= '0;
      per_r    <= '0;
      tkn_r    <= '0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        thr_task_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      ptr_r    <= ptr_nxt;
      thr_en_r <= thr_en_nxt;
      has_r    <= has_nxt;
      used_r   <= used_nxt;
      ten_r    <= ten_nxt;
      per_r    <= per_nxt;
      tkn_r    <= tkn_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
      thr_task_r <= thr_task_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    pq_r    <= pq_nxt;
    pp_r    <= pp_nxt;
    pk_r    <= pk_nxt;
    att_r   <= att_nxt;
    now_r   <= now_nxt;
    o_thr_r <= o_thr_nxt;
    o_tv_r  <= o_tv_nxt;
    o_tk_r  <= o_tk_nxt;
    o_q_r   <= o_q_nxt;
    o_acc_r <= o_acc_nxt;
    o_na_r  <= o_na_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    ptr_nxt      = ptr_r;
    thr_en_nxt   = thr_en_r;
    has_nxt      = has_r;
    thr_task_nxt = thr_task_r;
    used_nxt     = used_r;
    ten_nxt      = ten_r;
    per_nxt      = per_r;
    tkn_nxt      = tkn_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    pq_nxt       = pq_r;
    pp_nxt       = pp_r;
    pk_nxt       = pk_r;
    att_nxt      = att_r;
    now_nxt      = now_r;
    ov_nxt       = ov_r && out_stall;
    o_thr_nxt    = o_thr_r;
    o_tv_nxt     = o_tv_r;
    o_tk_nxt     = o_tk_r;
    o_q_nxt      = o_q_r;
    o_acc_nxt    = o_acc_r;
    o_na_nxt     = o_na_r;
    ram_we       = 1'b0;
    ram_waddr    = free_k;
    ram_wdata    = '{period: in_period_ticks, last_run: in_now_tick, slice: in_quanta_budget};
    ram_re       = 1'b0;
    ram_raddr    = scan_k;

    unique case (state_r)
      rrs_pkg::S_IDLE: begin
        if (accept) begin
          now_nxt = in_now_tick;
          att_nxt = 1'b0;
          if (in_action == rrs_pkg::ACT_SCHEDULE) begin
            cur_nxt = pick_en;
            cnt_nxt = '0;
            if (has_r[pick_en]) begin
              ptr_nxt   = (ptr_inc >= (TW + 1)'(TASKS)) ? '0 : TW'(ptr_inc);
              state_nxt = rrs_pkg::S_READ;
            end else begin
              state_nxt = rrs_pkg::S_SCAN;
            end
          end else begin
            ov_nxt    = 1'b1;
            o_thr_nxt = '0;
            o_tv_nxt  = 1'b0;
            o_tk_nxt  = '0;
            o_q_nxt   = '0;
            o_acc_nxt = 1'b0;
            o_na_nxt  = 1'b0;
            case (in_action)
              rrs_pkg::ACT_CREATE: begin
                if (free_found) begin
                  used_nxt[free_k] = 1'b1;
                  ten_nxt[free_k]  = 1'b0;
                  per_nxt[free_k]  = in_loop_flag;
                  tkn_nxt[free_k]  = 1'b0;
                  ram_we           = 1'b1;
                  o_tk_nxt         = 4'(32'(free_k));
                  o_acc_nxt        = 1'b1;
                end
              end
              rrs_pkg::ACT_REMOVE: begin
                if (32'(in_slot) < TASKS) begin
                  used_nxt[slot_k] = 1'b0;
                  o_acc_nxt        = 1'b1;
                end
              end
              rrs_pkg::ACT_TASK_EN: begin
                if (32'(in_slot) < TASKS && used_r[slot_k] &&
                    ten_r[slot_k] != in_enable_flag) begin
                  ten_nxt[slot_k] = in_enable_flag;
                  o_acc_nxt       = 1'b1;
                end
              end
              rrs_pkg::ACT_THR_EN: begin
                if (32'(in_slot) < THREADS && thr_en_r[slot_t] != in_enable_flag) begin
                  thr_en_nxt[slot_t] = in_enable_flag;
                  o_acc_nxt          = 1'b1;
                end
              end
              rrs_pkg::ACT_RELEASE: begin
                if (32'(in_slot) < THREADS && has_r[slot_t]) begin
                  has_nxt[slot_t] = 1'b0;
                  tkn_nxt[thr_task_r[slot_t]] = 1'b0;
                  if (!per_r[thr_task_r[slot_t]]) begin
                    used_nxt[thr_task_r[slot_t]] = 1'b0;
                  end
                  o_acc_nxt = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      rrs_pkg::S_SCAN: begin
        if (pend_r && qual) begin
          ram_we              = 1'b1;
          ram_waddr           = pk_r;
          ram_wdata           = '{period: ram_rdata.period, last_run: now_r,
                                  slice: ram_rdata.slice};
          tkn_nxt[pk_r]       = 1'b1;
          has_nxt[cur_r]      = 1'b1;
          thr_task_nxt[cur_r] = pk_r;
          ptr_nxt   = (pk_inc >= (TW + 1)'(TASKS)) ? '0 : TW'(pk_inc);
          att_nxt   = 1'b1;
          state_nxt = rrs_pkg::S_READ;
        end else if (cnt_r < (TW + 1)'(TASKS)) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pk_nxt   = scan_k;
          pq_nxt   = used_r[scan_k] && ten_r[scan_k] && !tkn_r[scan_k];
          pp_nxt   = per_r[scan_k];
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          state_nxt = rrs_pkg::S_HOP;
        end
      end
      rrs_pkg::S_HOP: begin
        cur_nxt   = pick_has;
        ptr_nxt   = (ptr_inc >= (TW + 1)'(TASKS)) ? '0 : TW'(ptr_inc);
        state_nxt = rrs_pkg::S_READ;
      end
      rrs_pkg::S_READ: begin
        ram_re    = has_r[cur_r];
        ram_raddr = thr_task_r[cur_r];
        state_nxt = rrs_pkg::S_RESP;
      end
      rrs_pkg::S_RESP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_thr_nxt = 2'(32'(cur_r));
          o_tv_nxt  = has_r[cur_r];
          o_tk_nxt  = has_r[cur_r] ? 4'(32'(thr_task_r[cur_r])) : '0;
          o_q_nxt   = has_r[cur_r] ? ram_rdata.slice : '0;
          o_acc_nxt = has_r[cur_r];
          o_na_nxt  = att_r;
          state_nxt = rrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrs_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid          = ov_r;
  assign out_thread_index   = o_thr_r;
  assign out_task_valid     = o_tv_r;
  assign out_task_index     = o_tk_r;
  assign out_quanta         = o_q_r;
  assign out_accepted       = o_acc_r;
  assign out_newly_attached = o_na_r;

endmodule

@@ design/rrs_checker.sv @@
// Port-level checks of the scheduler and their binding to the top level.
module rrs_assert (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_quanta,
  input logic        out_task_valid,
  input logic        out_accepted,
  input logic        out_newly_attached
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quanta))
    else $error("result changed while stalled");

  a_attach: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_newly_attached |-> out_task_valid)
    else $error("attach without task");

  a_task_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_task_valid |-> out_accepted)
    else $error("task reported but not accepted");

  a_quanta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_task_valid |-> out_quanta == 16'd0)
    else $error("quanta without task");

endmodule

bind thread_task_round_robin_scheduler_unit rrs_assert u_rrs_assert (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_quanta         (out_quanta),
  .out_task_valid     (out_task_valid),
  .out_accepted       (out_accepted),
  .out_newly_attached (out_newly_attached)
);

@@ tb/sv/rrs_checker.sv @@
// Checker for the round-robin scheduler: predicts each transaction and compares results.
module rrs_checker #(
  parameter int THREADS = 4,
  parameter int TASKS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_slot,
  input  logic        in_enable_flag,
  input  logic        in_loop_flag,
  input  logic [31:0] in_period_ticks,
  input  logic [15:0] in_quanta_budget,
  input  logic [31:0] in_now_tick,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_thread_index,
  input  logic        out_task_valid,
  input  logic [3:0]  out_task_index,
  input  logic [15:0] out_quanta,
  input  logic        out_accepted,
  input  logic        out_newly_attached,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  thread_index;
    logic        task_valid;
    logic [3:0]  task_index;
    logic [15:0] quanta;
    logic        accepted;
    logic        newly_attached;
  } dispatch_t;

  dispatch_t expected_q[$];

  int          cur_thread;
  int          task_ptr;
  bit          thr_en[THREADS];
  bit          thr_busy[THREADS];
  int          thr_task[THREADS];
  bit          tk_used[TASKS];
  bit          tk_en[TASKS];
  bit          tk_loop[TASKS];
  bit          tk_taken[TASKS];
  logic [31:0] tk_period[TASKS];
  logic [31:0] tk_last[TASKS];
  logic [15:0] tk_slice[TASKS];

  function automatic int step_thread(int t);
    return (t + 1 >= THREADS) ? 0 : t + 1;
  endfunction

  function automatic void clear_tables();
    cur_thread = 0;
    task_ptr = 0;
    for (int i = 0; i < THREADS; i++) begin
      thr_en[i] = 0; thr_busy[i] = 0; thr_task[i] = 0;
    end
    for (int i = 0; i < TASKS; i++) begin
      tk_used[i] = 0; tk_en[i] = 0; tk_loop[i] = 0; tk_taken[i] = 0;
      tk_period[i] = '0; tk_last[i] = '0; tk_slice[i] = '0;
    end
  endfunction

  function automatic dispatch_t dispatch_next(logic [31:0] now);
    dispatch_t r;
    int start, k;
    bit attached;
    logic [31:0] age;
    r = '0;
    attached = 0;
    cur_thread = step_thread(cur_thread % THREADS);
    start = cur_thread;
    for (int n = 0; n < THREADS && !thr_en[cur_thread]; n++) begin
      cur_thread = step_thread(cur_thread);
      if (cur_thread == start) break;
    end
    if (!thr_busy[cur_thread]) begin
      for (int n = 0; n < TASKS; n++) begin
        k = (task_ptr + n) % TASKS;
        if (!tk_used[k] || !tk_en[k] || tk_taken[k]) continue;
        age = now - tk_last[k];
        if (tk_loop[k] && age < tk_period[k]) continue;
        tk_taken[k] = 1;
        tk_last[k] = now;
        thr_busy[cur_thread] = 1;
        thr_task[cur_thread] = k;
        task_ptr = k;
        attached = 1;
        break;
      end
      if (!attached) begin
        cur_thread = step_thread(cur_thread);
        start = cur_thread;
        for (int n = 0; n < THREADS && !thr_busy[cur_thread]; n++) begin
          cur_thread = step_thread(cur_thread);
          if (cur_thread == start) break;
        end
      end
    end
    task_ptr = (task_ptr + 1 >= TASKS) ? 0 : task_ptr + 1;
    r.thread_index = cur_thread[1:0];
    if (thr_busy[cur_thread]) begin
      r.task_valid = 1;
      r.task_index = thr_task[cur_thread][3:0];
      r.quanta = (thr_task[cur_thread] < TASKS) ? tk_slice[thr_task[cur_thread]] : '0;
      r.accepted = 1;
    end
    r.newly_attached = attached;
    return r;
  endfunction

  function automatic dispatch_t predict_transaction();
    dispatch_t r;
    int s, k;
    r = '0;
    s = in_slot;
    case (in_action)
      rrs_pkg::ACT_SCHEDULE: r = dispatch_next(in_now_tick);
      rrs_pkg::ACT_CREATE: begin
        for (k = 0; k < TASKS; k++) begin
          if (tk_used[k]) continue;
          tk_used[k] = 1; tk_en[k] = 0; tk_loop[k] = in_loop_flag; tk_taken[k] = 0;
          tk_period[k] = in_period_ticks; tk_last[k] = in_now_tick;
          tk_slice[k] = in_quanta_budget;
          r.task_index = k[3:0];
          r.accepted = 1;
          break;
        end
      end
      rrs_pkg::ACT_REMOVE: begin
        if (s < TASKS) begin
          tk_used[s] = 0;
          r.accepted = 1;
        end
      end
      rrs_pkg::ACT_TASK_EN: begin
        if (s < TASKS && tk_used[s] && tk_en[s] != in_enable_flag) begin
          tk_en[s] = in_enable_flag;
          r.accepted = 1;
        end
      end
      rrs_pkg::ACT_THR_EN: begin
        if (s < THREADS && thr_en[s] != in_enable_flag) begin
          thr_en[s] = in_enable_flag;
          r.accepted = 1;
        end
      end
      rrs_pkg::ACT_RELEASE: begin
        if (s < THREADS && thr_busy[s]) begin
          k = thr_task[s];
          thr_busy[s] = 0;
          if (k < TASKS) begin
            tk_taken[k] = 0;
            if (!tk_loop[k]) tk_used[k] = 0;
          end
          r.accepted = 1;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_tables();
  end

  always @(posedge clk) begin
    dispatch_t exp_r;
    if (!rst_n) begin
      clear_tables();
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(predict_transaction());
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_thread_index !== exp_r.thread_index)
            report_mismatch("thread_index", out_thread_index, exp_r.thread_index);
          if (out_task_valid !== exp_r.task_valid)
            report_mismatch("task_valid", out_task_valid, exp_r.task_valid);
          if (out_task_index !== exp_r.task_index)
            report_mismatch("task_index", out_task_index, exp_r.task_index);
          if (out_quanta !== exp_r.quanta)
            report_mismatch("quanta", out_quanta, exp_r.quanta);
          if (out_accepted !== exp_r.accepted)
            report_mismatch("accepted", out_accepted, exp_r.accepted);
          if (out_newly_attached !== exp_r.newly_attached)
            report_mismatch("newly_attached", out_newly_attached, exp_r.newly_attached);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the scheduler.
module tb;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [3:0]  in_slot;
  logic        in_enable_flag;
  logic        in_loop_flag;
  logic [31:0] in_period_ticks;
  logic [15:0] in_quanta_budget;
  logic [31:0] in_now_tick;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_thread_index;
  logic        out_task_valid;
  logic [3:0]  out_task_index;
  logic [15:0] out_quanta;
  logic        out_accepted;
  logic        out_newly_attached;
  int          fail_count;
  int          pending;

  int          hold_cycles;
  int          stall_run;
  bit          calm;
  int          idle_cycles;
  logic [31:0] tick_now;

  thread_task_round_robin_scheduler_unit u_top (.*);
  rrs_checker u_checker (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_action = rrs_pkg::ACT_SCHEDULE; in_slot = '0;
    in_enable_flag = 1'b0; in_loop_flag = 1'b0; in_period_ticks = '0;
    in_quanta_budget = '0; in_now_tick = '0;
    out_stall = 1'b0;
    hold_cycles = 0; stall_run = 0; calm = 0; idle_cycles = 0; tick_now = '0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else if (stall_run > 0) begin
      out_stall = 1'b1;
      stall_run--;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_stall = 1'b1;
      stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 3);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] act, logic [3:0] slot, logic en, logic lp,
                           logic [31:0] period, logic [15:0] budget, logic [31:0] now);
    int gap;
    in_action = act; in_slot = slot; in_enable_flag = en; in_loop_flag = lp;
    in_period_ticks = period; in_quanta_budget = budget; in_now_tick = now;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (calm) gap = 0;
    else if ($urandom_range(0, 9) < 6) gap = 0;
    else if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 30);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_item(output bit counted);
    int pick;
    logic [2:0] act;
    logic [3:0] slot;
    logic [31:0] period, now;
    pick = $urandom_range(0, 99);
    if (pick < 40) act = rrs_pkg::ACT_SCHEDULE;
    else if (pick < 52) act = rrs_pkg::ACT_CREATE;
    else if (pick < 58) act = rrs_pkg::ACT_REMOVE;
    else if (pick < 72) act = rrs_pkg::ACT_TASK_EN;
    else if (pick < 82) act = rrs_pkg::ACT_THR_EN;
    else if (pick < 97) act = rrs_pkg::ACT_RELEASE;
    else act = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
    if ((act == rrs_pkg::ACT_THR_EN || act == rrs_pkg::ACT_RELEASE) &&
        $urandom_range(0, 9) != 0)
      slot = 4'($urandom_range(0, 3));
    else slot = 4'($urandom_range(0, 15));
    period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 24);
    tick_now = tick_now + $urandom_range(0, 8);
    now = ($urandom_range(0, 29) == 0) ? $urandom : tick_now;
    send_item(act, slot, $urandom_range(0, 9) < 7, 1'($urandom_range(0, 1)), period,
              ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)), now);
    counted = (act != ACT_SPARE_LO && act != ACT_SPARE_HI);
  endtask

  initial begin
    int done;
    bit counted;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    // directed corners
    send_item(rrs_pkg::ACT_SCHEDULE, 4'd0, 1'b0, 1'b0, '0, '0, '0);
    send_item(rrs_pkg::ACT_THR_EN, 4'd0, 1'b1, 1'b0, '0, '0, 32'd1);
    send_item(rrs_pkg::ACT_THR_EN, 4'd0, 1'b1, 1'b0, '0, '0, 32'd1);
    send_item(rrs_pkg::ACT_THR_EN, 4'd15, 1'b1, 1'b0, '0, '0, 32'd1);
    send_item(rrs_pkg::ACT_SCHEDULE, 4'd0, 1'b0, 1'b0, '0, '0, 32'd2);
    send_item(rrs_pkg::ACT_CREATE, 4'd0, 1'b0, 1'b0, '0, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(rrs_pkg::ACT_CREATE, 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'h0000, 32'd0);
    send_item(rrs_pkg::ACT_TASK_EN, 4'd0, 1'b1, 1'b0, '0, '0, 32'd3);
    send_item(rrs_pkg::ACT_TASK_EN, 4'd1, 1'b1, 1'b0, '0, '0, 32'd3);
    send_item(rrs_pkg::ACT_TASK_EN, 4'd15, 1'b1, 1'b0, '0, '0, 32'd3);
    send_item(rrs_pkg::ACT_SCHEDULE, 4'd0, 1'b0, 1'b0, '0, '0, 32'd4);
    send_item(rrs_pkg::ACT_SCHEDULE, 4'd0, 1'b0, 1'b0, '0, '0, 32'hFFFF_FFFE);
    send_item(rrs_pkg::ACT_RELEASE, 4'd0, 1'b0, 1'b0, '0, '0, 32'd5);
    send_item(rrs_pkg::ACT_RELEASE, 4'd0, 1'b0, 1'b0, '0, '0, 32'd5);
    send_item(rrs_pkg::ACT_RELEASE, 4'd12, 1'b0, 1'b0, '0, '0, 32'd5);
    send_item(rrs_pkg::ACT_REMOVE, 4'd15, 1'b0, 1'b0, '0, '0, 32'd6);
    send_item(rrs_pkg::ACT_TASK_EN, 4'd1, 1'b0, 1'b0, '0, '0, 32'd6);
    send_item(ACT_SPARE_LO, 4'hF, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_SPARE_HI, 4'd0, 1'b0, 1'b0, '0, '0, '0);
    for (int i = 0; i < 17; i++)
      send_item(rrs_pkg::ACT_CREATE, 4'd0, 1'b0, i[0], i, 16'(i), 32'd7);
    for (int i = 0; i < 16; i += 2)
      send_item(rrs_pkg::ACT_REMOVE, i[3:0], 1'b0, 1'b0, '0, '0, 32'd8);
    tick_now = 32'd8;

    // sender pauses until the block has drained
    drain_results();
    done = 0;
    while (done < 550) begin
      if (done == 150) begin
        calm = 1;
        hold_cycles = 300;
      end
      if (done == 200) calm = 0;
      if (done == 300 || done == 450) drain_results();
      if (done == 350) calm = 1;
      if (done == 400) calm = 0;
      random_item(counted);
      if (counted) done++;
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
